@@ design/adi_pkg.sv @@
// Shared types, codes and fixed formats of the acceleration double integrator.
`default_nettype none

package adi_pkg;

   // Word field widths
   localparam int ACTION_W = 2;
   localparam int ACCEL_W  = 32;
   localparam int STAMP_W  = 48;
   localparam int VAL_W    = 48;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int THR_W      = 31;
   localparam int LIM_W      = 16;

   // Fraction bits of velocity and displacement
   localparam int VD_FRAC = 28;

   // Shared multiplier: full operand by one chunk of the other per cycle
   localparam int MUL_OP_W    = 48;
   localparam int MUL_CHUNK_W = 16;
   localparam int MUL_CHUNKS  = MUL_OP_W / MUL_CHUNK_W;
   localparam int MUL_ACC_W   = MUL_OP_W + MUL_CHUNK_W;
   localparam int PROD_W      = 2 * MUL_OP_W;
   localparam int MUL_CNT_W   = $clog2(MUL_CHUNKS);

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_THR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_THR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_MIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_LIM = 3'd4;

   // Register reset values
   localparam logic [THR_W-1:0] RST_DISP_THR = 31'd25105;
   localparam logic [THR_W-1:0] RST_LOG_THR  = 31'd25105;
   localparam logic [LIM_W-1:0] RST_VEL_MIN  = 16'd15;
   localparam logic [LIM_W-1:0] RST_DISP_MIN = 16'd2;
   localparam logic [LIM_W-1:0] RST_DISP_LIM = 16'd400;

   // Saturation bounds of the 48 bit signed results
   localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_PREP  = 10'b0000000010,
      ST_DELTA = 10'b0000000100,
      ST_LOAD  = 10'b0000001000,
      ST_MUL   = 10'b0000010000,
      ST_RND   = 10'b0000100000,
      ST_SAT   = 10'b0001000000,
      ST_ACC   = 10'b0010000000,
      ST_LIMIT = 10'b0100000000,
      ST_CHECK = 10'b1000000000
   } state_type;

endpackage

`default_nettype wire

@@ design/accel_double_integrator.sv @@
// Top level: streaming double integrator of timestamped acceleration words.
//
//  channel  direction  handshake               payload
//  req_     in         req_valid / req_ready   action, accel, stamp
//  rsp_     out        rsp_valid / rsp_ready   velocity_display, velocity_log, displacement
//  csr_     in         csr_valid / csr_ready   index, data
//
// An add word steps through the accepting cycle, relative time, time step, two
// passes (load, multiplier forming three 48x16 partial products, round, saturate,
// accumulate) for velocity and then displacement, and the limit check.
// Clear and unknown actions are done in the accepting cycle. A finish word moves to
// a check state and waits in place while an earlier result is still unclaimed; once
// loaded, the result register lets later words in while it waits.
// Reset is synchronous; it clears the series state and restores the registers.
// csr_ready is always high.
`default_nettype none

module accel_double_integrator
   import adi_pkg::*;
#(
   parameter int TIME_FRAC_BITS = 20
)
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input words
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic        [ACTION_W-1:0]   req_action,
   input  wire logic signed [ACCEL_W-1:0]    req_accel,
   input  wire logic        [STAMP_W-1:0]    req_stamp,
   // result words
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed      [VAL_W-1:0]      rsp_velocity_display,
   output logic signed      [VAL_W-1:0]      rsp_velocity_log,
   output logic signed      [VAL_W-1:0]      rsp_displacement,
   // register writes
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic        [CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [CSR_DATA_W-1:0] csr_data
);

   // Velocity step: the sum of two Q.8 samples is twice their mean, so the sum times
   // dt (at TIME_FRAC_BITS) reads as Q.(9+TFB), scaled to Q.28
   localparam int DV_SHIFT = TIME_FRAC_BITS + 9 - VD_FRAC;
   localparam int SUM_W    = ACCEL_W + 1;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type                 state_ff, state_in;

   logic [THR_W-1:0]          disp_thr_ff, disp_thr_in;
   logic [THR_W-1:0]          log_thr_ff, log_thr_in;
   logic [LIM_W-1:0]          vel_min_ff, vel_min_in;
   logic [LIM_W-1:0]          disp_min_ff, disp_min_in;
   logic [LIM_W-1:0]          disp_lim_ff, disp_lim_in;

   // series state
   logic [STAMP_W-1:0]        start_ff, start_in;
   logic [STAMP_W-1:0]        prev_rel_ff, prev_rel_in;
   logic signed [ACCEL_W-1:0] prev_sample_ff, prev_sample_in;
   logic signed [VAL_W-1:0]   velocity_ff, velocity_in;
   logic signed [VAL_W-1:0]   distance_ff, distance_in;
   logic                      seen_disp_ff, seen_disp_in;
   logic                      seen_log_ff, seen_log_in;

   // working registers of one add word
   logic signed [ACCEL_W-1:0] accel_ff, accel_in;
   logic [STAMP_W-1:0]        stamp_ff, stamp_in;
   logic [STAMP_W-1:0]        rel_ff, rel_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [STAMP_W-1:0]        dt_mag_ff, dt_mag_in;
   logic                      dt_neg_ff, dt_neg_in;
   logic                      neg_ff, neg_in;
   logic                      pass_ff, pass_in;
   logic [VAL_W-1:0]          mag_ff, mag_in;
   logic                      over_ff, over_in;
   logic signed [VAL_W-1:0]   addend_ff, addend_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]   rsp_vdisp_ff, rsp_vdisp_in;
   logic signed [VAL_W-1:0]   rsp_vlog_ff, rsp_vlog_in;
   logic signed [VAL_W-1:0]   rsp_disp_ff, rsp_disp_in;

   // ---------------------------------------------------------------------
   // Shared multiplier
   // ---------------------------------------------------------------------
   logic                      mul_start;
   logic [MUL_OP_W-1:0]       mul_a;
   logic [MUL_OP_W-1:0]       mul_b;
   logic                      mul_done;
   logic [PROD_W-1:0]         mul_product;

   adi_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   // Operand magnitudes: accel sum on the velocity pass, velocity on the displacement pass
   logic [SUM_W-1:0]          sum_mag;
   logic [VAL_W-1:0]          vel_mag;
   logic [VAL_W-1:0]          dist_mag;

   assign sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign vel_mag  = velocity_ff[VAL_W-1] ? VAL_W'(-velocity_ff) : VAL_W'(velocity_ff);
   assign dist_mag = distance_ff[VAL_W-1] ? VAL_W'(-distance_ff) : VAL_W'(distance_ff);

   assign mul_start = (state_ff == ST_LOAD);
   assign mul_a     = pass_ff ? vel_mag : MUL_OP_W'(sum_mag);
   assign mul_b     = dt_mag_ff;

   // ---------------------------------------------------------------------
   // Rounding of the product: nearest, ties away from zero (on the magnitude)
   // ---------------------------------------------------------------------
   logic [VAL_W-1:0]          rnd0_mag;
   logic                      rnd0_over;
   logic [PROD_W-1:0]         rnd1;

   generate
      if (DV_SHIFT > 0) begin : g_dv_right
         logic [PROD_W-1:0] rnd0;
         assign rnd0      = (mul_product >> DV_SHIFT) + PROD_W'(mul_product[DV_SHIFT-1]);
         assign rnd0_over = |rnd0[PROD_W-1:VAL_W];
         assign rnd0_mag  = rnd0[VAL_W-1:0];
      end else if (DV_SHIFT == 0) begin : g_dv_none
         assign rnd0_over = |mul_product[PROD_W-1:VAL_W];
         assign rnd0_mag  = mul_product[VAL_W-1:0];
      end else begin : g_dv_left
         localparam int NK = -DV_SHIFT;
         logic [PROD_W+NK-1:0] shl;
         assign shl       = {mul_product, {NK{1'b0}}};
         assign rnd0_over = |shl[PROD_W+NK-1:VAL_W];
         assign rnd0_mag  = shl[VAL_W-1:0];
      end
   endgenerate

   assign rnd1 = (mul_product >> TIME_FRAC_BITS) + PROD_W'(mul_product[TIME_FRAC_BITS-1]);

   // ---------------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------------
   logic [ACCEL_W-1:0]        accel_mag;
   logic [VAL_W-1:0]          sat_lim;
   logic [VAL_W-1:0]          sat_mag;
   logic signed [VAL_W-1:0]   acc_target;
   logic signed [VAL_W:0]     acc_sum;
   logic signed [VAL_W-1:0]   acc_result;
   logic signed [VAL_W-1:0]   lim_value;
   logic [VAL_W-1:0]          vmin_value;
   logic [VAL_W-1:0]          dmin_value;
   logic                      vel_ok;
   logic                      dist_ok;
   logic                      req_take;
   logic                      rsp_free;

   assign accel_mag  = accel_ff[ACCEL_W-1] ? ACCEL_W'(-accel_ff) : ACCEL_W'(accel_ff);

   assign sat_lim    = neg_ff ? NEG_MIN : POS_MAX;
   assign sat_mag    = (over_ff || (mag_ff > sat_lim)) ? sat_lim : mag_ff;

   assign acc_target = pass_ff ? distance_ff : velocity_ff;
   assign acc_sum    = {acc_target[VAL_W-1], acc_target} + {addend_ff[VAL_W-1], addend_ff};
   assign acc_result = (acc_sum[VAL_W] != acc_sum[VAL_W-1]) ?
                       (acc_sum[VAL_W] ? NEG_MIN : POS_MAX) : acc_sum[VAL_W-1:0];

   assign lim_value  = {{(VAL_W-LIM_W-VD_FRAC){1'b0}}, disp_lim_ff, {VD_FRAC{1'b0}}};
   assign vmin_value = {{(VAL_W-LIM_W-VD_FRAC){1'b0}}, vel_min_ff, {VD_FRAC{1'b0}}};
   assign dmin_value = {{(VAL_W-LIM_W-VD_FRAC){1'b0}}, disp_min_ff, {VD_FRAC{1'b0}}};
   assign vel_ok     = vel_mag > vmin_value;
   assign dist_ok    = dist_mag > dmin_value;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // Sequencer and datapath
   // ---------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      disp_thr_in    = disp_thr_ff;
      log_thr_in     = log_thr_ff;
      vel_min_in     = vel_min_ff;
      disp_min_in    = disp_min_ff;
      disp_lim_in    = disp_lim_ff;
      start_in       = start_ff;
      prev_rel_in    = prev_rel_ff;
      prev_sample_in = prev_sample_ff;
      velocity_in    = velocity_ff;
      distance_in    = distance_ff;
      seen_disp_in   = seen_disp_ff;
      seen_log_in    = seen_log_ff;
      accel_in       = accel_ff;
      stamp_in       = stamp_ff;
      rel_in         = rel_ff;
      sum_in         = sum_ff;
      dt_mag_in      = dt_mag_ff;
      dt_neg_in      = dt_neg_ff;
      neg_in         = neg_ff;
      pass_in        = pass_ff;
      mag_in         = mag_ff;
      over_in        = over_ff;
      addend_in      = addend_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_vdisp_in   = rsp_vdisp_ff;
      rsp_vlog_in    = rsp_vlog_ff;
      rsp_disp_in    = rsp_disp_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DISP_THR: disp_thr_in = csr_data[THR_W-1:0];
            CSR_LOG_THR:  log_thr_in  = csr_data[THR_W-1:0];
            CSR_VEL_MIN:  vel_min_in  = csr_data[LIM_W-1:0];
            CSR_DISP_MIN: disp_min_in = csr_data[LIM_W-1:0];
            CSR_DISP_LIM: disp_lim_in = csr_data[LIM_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               accel_in = req_accel;
               stamp_in = req_stamp;
               case (req_action)
                  ACT_CLEAR: begin
                     start_in       = req_stamp;
                     prev_rel_in    = '0;
                     prev_sample_in = '0;
                     velocity_in    = '0;
                     distance_in    = '0;
                     seen_disp_in   = 1'b0;
                     seen_log_in    = 1'b0;
                  end
                  ACT_ADD:    state_in = ST_PREP;
                  ACT_FINISH: state_in = ST_CHECK;
                  default: ;
               endcase
            end
         end
         ST_PREP: begin
            // relative time wraps like a free running timer
            rel_in = stamp_ff - start_ff;
            sum_in = SUM_W'(prev_sample_ff) + SUM_W'(accel_ff);
            if (accel_mag > ACCEL_W'(disp_thr_ff)) begin
               seen_disp_in = 1'b1;
            end
            if (accel_mag > ACCEL_W'(log_thr_ff)) begin
               seen_log_in = 1'b1;
            end
            state_in = ST_DELTA;
         end
         ST_DELTA: begin
            dt_neg_in = rel_ff < prev_rel_ff;
            dt_mag_in = (rel_ff < prev_rel_ff) ? (prev_rel_ff - rel_ff) : (rel_ff - prev_rel_ff);
            pass_in   = 1'b0;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            // multiplier takes its operands this cycle
            neg_in   = (pass_ff ? velocity_ff[VAL_W-1] : sum_ff[SUM_W-1]) ^ dt_neg_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            if (pass_ff) begin
               over_in = |rnd1[PROD_W-1:VAL_W];
               mag_in  = rnd1[VAL_W-1:0];
            end else begin
               over_in = rnd0_over;
               mag_in  = rnd0_mag;
            end
            state_in = ST_SAT;
         end
         ST_SAT: begin
            addend_in = neg_ff ? VAL_W'(-sat_mag) : VAL_W'(sat_mag);
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            if (pass_ff) begin
               distance_in = acc_result;
               state_in    = ST_LIMIT;
            end else begin
               // advance to the displacement pass on the new velocity
               velocity_in = acc_result;
               pass_in     = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LIMIT: begin
            if (distance_ff > lim_value) begin
               velocity_in = '0;
               distance_in = '0;
            end
            prev_rel_in    = rel_ff;
            prev_sample_in = accel_ff;
            state_in       = ST_IDLE;
         end
         ST_CHECK: begin
            // hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_vdisp_in = (seen_disp_ff && vel_ok && dist_ok) ? velocity_ff : '0;
               rsp_vlog_in  = seen_log_ff ? velocity_ff : '0;
               rsp_disp_in  = distance_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         disp_thr_ff    <= RST_DISP_THR;
         log_thr_ff     <= RST_LOG_THR;
         vel_min_ff     <= RST_VEL_MIN;
         disp_min_ff    <= RST_DISP_MIN;
         disp_lim_ff    <= RST_DISP_LIM;
         start_ff       <= '0;
         prev_rel_ff    <= '0;
         prev_sample_ff <= '0;
         velocity_ff    <= '0;
         distance_ff    <= '0;
         seen_disp_ff   <= 1'b0;
         seen_log_ff    <= 1'b0;
         pass_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         disp_thr_ff    <= disp_thr_in;
         log_thr_ff     <= log_thr_in;
         vel_min_ff     <= vel_min_in;
         disp_min_ff    <= disp_min_in;
         disp_lim_ff    <= disp_lim_in;
         start_ff       <= start_in;
         prev_rel_ff    <= prev_rel_in;
         prev_sample_ff <= prev_sample_in;
         velocity_ff    <= velocity_in;
         distance_ff    <= distance_in;
         seen_disp_ff   <= seen_disp_in;
         seen_log_ff    <= seen_log_in;
         pass_ff        <= pass_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      accel_ff     <= accel_in;
      stamp_ff     <= stamp_in;
      rel_ff       <= rel_in;
      sum_ff       <= sum_in;
      dt_mag_ff    <= dt_mag_in;
      dt_neg_ff    <= dt_neg_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      over_ff      <= over_in;
      addend_ff    <= addend_in;
      rsp_vdisp_ff <= rsp_vdisp_in;
      rsp_vlog_ff  <= rsp_vlog_in;
      rsp_disp_ff  <= rsp_disp_in;
   end

   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_velocity_display = rsp_vdisp_ff;
   assign rsp_velocity_log     = rsp_vlog_ff;
   assign rsp_displacement     = rsp_disp_ff;

endmodule

`default_nettype wire

@@ design/adi_mul.sv @@
// Chunk-serial unsigned multiplier, 48 by 48 bits.
`default_nettype none

module adi_mul
   import adi_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [MUL_OP_W-1:0] op_a,
   input  wire logic [MUL_OP_W-1:0] op_b,
   output logic                     done,
   output logic [PROD_W-1:0]        product
);

   localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(MUL_CHUNKS - 1);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [MUL_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MUL_OP_W-1:0]   a_ff, a_in;
   logic [MUL_OP_W-1:0]   b_ff, b_in;
   logic [MUL_ACC_W-1:0]  acc_ff, acc_in;
   logic [MUL_OP_W-1:0]   lo_ff, lo_in;
   logic [MUL_ACC_W-1:0]  partial;
   logic [MUL_ACC_W-1:0]  step_sum;

   // One partial product per cycle, low chunk of b first
   assign partial  = a_ff * b_ff[MUL_CHUNK_W-1:0];
   assign step_sum = {{MUL_CHUNK_W{1'b0}}, acc_ff[MUL_ACC_W-1:MUL_CHUNK_W]} + partial;

   always_comb begin
      run_in  = run_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      if (start) begin
         run_in  = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
      end else if (run_ff) begin
         acc_in = step_sum;
         lo_in  = {step_sum[MUL_CHUNK_W-1:0], lo_ff[MUL_OP_W-1:MUL_CHUNK_W]};
         b_in   = {{MUL_CHUNK_W{1'b0}}, b_ff[MUL_OP_W-1:MUL_CHUNK_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
   end

   assign done    = done_ff;
   assign product = {acc_ff[MUL_ACC_W-1:MUL_CHUNK_W], lo_ff};

endmodule

`default_nettype wire
